[sv/hdrat_pkg.sv]
// Shared constants, codes and the gamma level function of the HDR accumulator.
`timescale 1ns / 1ps
package hdrat_pkg;

	localparam int SAMPLE_W = 32;
	localparam int SUM_W    = 48;
	localparam int PIX_W    = 16;
	localparam int EXP_W    = 6;
	localparam int CNT_W    = 16;
	localparam int COLOR_W  = 8;

	localparam int DVD_W = 60;
	localparam int DVS_W = 42;
	localparam int REM_W = 43;
	localparam int MA_W  = 24;
	localparam int MB_W  = 21;
	localparam int PRD_W = MA_W + MB_W;
	localparam int SCL_W = 63;

	localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};
	localparam logic [MB_W-1:0]  X_CLAMP  = 21'd1048576;
	localparam logic [16:0]      ONE_Q16  = 17'd65536;
	localparam logic [MA_W-1:0]  CURVE_A  = 24'd164495;
	localparam logic [MA_W-1:0]  CURVE_B  = 24'd1966;
	localparam logic [MA_W-1:0]  CURVE_C  = 24'd159252;
	localparam logic [MA_W-1:0]  CURVE_D  = 24'd38666;
	localparam logic [DVS_W-1:0] CURVE_E_Q16 = 42'd9175 << 16;
	localparam logic [PRD_W-1:0] HALF_Q16 = 45'd32768;

	localparam logic CMD_ACCUMULATE = 1'b0;
	localparam logic CMD_RESOLVE    = 1'b1;
	localparam logic CFG_EXPOSURE   = 1'b0;
	localparam logic CFG_COUNT      = 1'b1;

	function automatic logic [199:0] ipow(logic [199:0] b, int unsigned e);
		logic [199:0] r;
		r = 200'd1;
		for (int unsigned j = 0; j < e; j++) begin
			r = r * b;
		end
		return r;
	endfunction

	// Largest k in 1..255 with ((2k-1)/510)^11 <= (i/span)^5, else 0.
	function automatic logic [7:0] gamma_level(int unsigned i, int unsigned span);
		logic [199:0] rhs;
		logic [199:0] lhs;
		logic [7:0]   lvl;
		logic [7:0]   t;
		rhs = ipow(200'd510, 11) * ipow(200'(i), 5);
		lvl = 8'd0;
		for (int b = 7; b >= 0; b--) begin
			t   = lvl | (8'd1 << b);
			lhs = ipow((200'(t) << 1) - 200'd1, 11) * ipow(200'(span), 5);
			if (lhs <= rhs) begin
				lvl = t;
			end
		end
		return lvl;
	endfunction

endpackage

[sv/hdr_accumulate_aces_tonemap.sv]
// Top level: HDR frame accumulator with ACES filmic resolve and gamma 2.2.
`timescale 1ns / 1ps
// After reset the block clears its accumulation store, one pixel per cycle, with
// busy high; configuration writes are taken meanwhile.
// An accumulate item holds busy after its accepting edge through a store read,
// then a saturating add and write back; no new item is taken until both are done.
// A resolve item holds busy through a store read, then for each colour channel
// twice through one radix-2 divider of 60 steps (for sum by sample count and for
// the curve quotient), five times through one 24x21 multiplier and a gamma table
// read, and then with done high; the next item can be taken once done falls.
// The colour appears with done high for exactly one cycle; the receiver cannot
// stall it. Items arriving while busy is high are not taken.
module hdr_accumulate_aces_tonemap #(
	parameter int PIXEL_COUNT      = 65536,
	parameter int GAMMA_TABLE_SIZE = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               command,
	input  logic [hdrat_pkg::PIX_W-1:0]        pixel_index,
	input  logic [hdrat_pkg::SAMPLE_W-1:0]     red_sample,
	input  logic [hdrat_pkg::SAMPLE_W-1:0]     green_sample,
	input  logic [hdrat_pkg::SAMPLE_W-1:0]     blue_sample,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_index,
	input  logic [hdrat_pkg::CNT_W-1:0]        cfg_data,
	output logic                               done,
	output logic [hdrat_pkg::PIX_W-1:0]        out_pixel,
	output logic [hdrat_pkg::COLOR_W-1:0]      red_out,
	output logic [hdrat_pkg::COLOR_W-1:0]      green_out,
	output logic [hdrat_pkg::COLOR_W-1:0]      blue_out
);

	localparam int AW   = $clog2(PIXEL_COUNT);
	localparam int GW   = $clog2(GAMMA_TABLE_SIZE);
	localparam int ROW_W = 3 * hdrat_pkg::SUM_W;
	localparam logic [hdrat_pkg::MB_W-1:0] SPAN = hdrat_pkg::MB_W'(GAMMA_TABLE_SIZE - 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(PIXEL_COUNT - 1);
	localparam logic [5:0] LAST_STEP = 6'(hdrat_pkg::DVD_W - 1);

	typedef enum logic [16:0] {
		ST_CLEAR  = 17'h00001,
		ST_IDLE   = 17'h00002,
		ST_ACC_RD = 17'h00004,
		ST_ACC_WR = 17'h00008,
		ST_RES_RD = 17'h00010,
		ST_RES_LD = 17'h00020,
		ST_CH_LD  = 17'h00040,
		ST_DIV_X  = 17'h00080,
		ST_MUL_A  = 17'h00100,
		ST_MUL_N  = 17'h00200,
		ST_MUL_C  = 17'h00400,
		ST_MUL_D  = 17'h00800,
		ST_DIV_Y  = 17'h01000,
		ST_MUL_I  = 17'h02000,
		ST_LUT    = 17'h04000,
		ST_LUT_WR = 17'h08000,
		ST_DONE   = 17'h10000
	} state_t;

	state_t state_q;

	logic [hdrat_pkg::EXP_W-1:0]    exp_q;
	logic [hdrat_pkg::CNT_W-1:0]    count_q;
	logic                           cmd_q;
	logic                           inside_q;
	logic [hdrat_pkg::PIX_W-1:0]    pix_q;
	logic [hdrat_pkg::SAMPLE_W-1:0] smp_q [3];
	logic [AW-1:0]                  addr_q;
	logic [AW-1:0]                  clr_q;

	logic [ROW_W-1:0] mem [PIXEL_COUNT];
	logic [ROW_W-1:0] rd_q;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [ROW_W-1:0] wdata;

	logic [hdrat_pkg::SUM_W-1:0]   sums_q [3];
	logic [1:0]                    ch_q;
	logic [hdrat_pkg::COLOR_W-1:0] color_q [3];

	logic [hdrat_pkg::DVD_W-1:0] dq_q;
	logic [hdrat_pkg::REM_W-1:0] rem_q;
	logic [hdrat_pkg::DVS_W-1:0] dvs_q;
	logic [5:0]                  step_q;
	logic [hdrat_pkg::REM_W-1:0] rem_sh;
	logic [hdrat_pkg::REM_W:0]   diff;

	logic [hdrat_pkg::MA_W-1:0]  mul_a;
	logic [hdrat_pkg::MB_W-1:0]  mul_b;
	logic [hdrat_pkg::PRD_W-1:0] prod_c;
	logic [hdrat_pkg::PRD_W-1:0] prod_q;
	logic [hdrat_pkg::MB_W-1:0]  x_q;
	logic [hdrat_pkg::DVS_W-1:0] num_q;
	logic [hdrat_pkg::MB_W-1:0]  x_c;
	logic [16:0]                 y_c;
	logic [hdrat_pkg::PRD_W-1:0] idx_full;
	logic [GW-1:0]               idx_c;

	logic [hdrat_pkg::COLOR_W-1:0] gamma_rom [GAMMA_TABLE_SIZE];
	logic [hdrat_pkg::COLOR_W-1:0] lut_q;
	logic [hdrat_pkg::SUM_W-1:0]   acc_new [3];
	logic [hdrat_pkg::CNT_W-1:0]   n_eff;
	logic [hdrat_pkg::SUM_W-1:0]   cur_sum;

	genvar gi;
	for (gi = 0; gi < GAMMA_TABLE_SIZE; gi++) begin : g_rom
		localparam logic [hdrat_pkg::COLOR_W-1:0] LEVEL =
			hdrat_pkg::gamma_level(gi, GAMMA_TABLE_SIZE - 1);
		assign gamma_rom[gi] = LEVEL;
	end

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = (state_q == ST_DONE);
	assign out_pixel = pix_q;
	assign red_out   = color_q[0];
	assign green_out = color_q[1];
	assign blue_out  = color_q[2];

	assign n_eff   = (count_q == '0) ? hdrat_pkg::CNT_W'(1) : count_q;
	assign cur_sum = sums_q[ch_q];

	always_comb begin
		logic [5:0]                     amt;
		logic [hdrat_pkg::SCL_W-1:0]    scl;
		logic [hdrat_pkg::SUM_W:0]      s;
		logic [hdrat_pkg::SUM_W-1:0]    old;
		amt = 6'(7'd64 - {1'b0, exp_q});
		for (int c = 0; c < 3; c++) begin
			old = rd_q[c*hdrat_pkg::SUM_W +: hdrat_pkg::SUM_W];
			if (exp_q[hdrat_pkg::EXP_W-1]) begin
				scl = hdrat_pkg::SCL_W'(smp_q[c]) >> amt;
			end else begin
				scl = hdrat_pkg::SCL_W'(smp_q[c]) << exp_q[4:0];
			end
			s = {1'b0, old} + {1'b0, scl[hdrat_pkg::SUM_W-1:0]};
			if (scl[hdrat_pkg::SCL_W-1:hdrat_pkg::SUM_W] != '0 || s[hdrat_pkg::SUM_W]) begin
				acc_new[c] = hdrat_pkg::SUM_MAX;
			end else begin
				acc_new[c] = s[hdrat_pkg::SUM_W-1:0];
			end
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = {acc_new[2], acc_new[1], acc_new[0]};
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (state_q == ST_ACC_WR) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[addr_q];
	end

	assign rem_sh = {rem_q[hdrat_pkg::REM_W-2:0], dq_q[hdrat_pkg::DVD_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

	assign x_c = (dq_q > hdrat_pkg::DVD_W'(hdrat_pkg::X_CLAMP)) ?
		hdrat_pkg::X_CLAMP : dq_q[hdrat_pkg::MB_W-1:0];
	assign y_c = (dq_q > hdrat_pkg::DVD_W'(hdrat_pkg::ONE_Q16)) ?
		hdrat_pkg::ONE_Q16 : dq_q[16:0];

	assign idx_full = (prod_q + hdrat_pkg::HALF_Q16) >> 16;
	assign idx_c = (idx_full >= hdrat_pkg::PRD_W'(GAMMA_TABLE_SIZE)) ?
		GW'(GAMMA_TABLE_SIZE - 1) : idx_full[GW-1:0];

	always_comb begin
		mul_a = hdrat_pkg::CURVE_A;
		mul_b = x_c;
		unique case (state_q)
			ST_MUL_N: begin
				mul_a = hdrat_pkg::MA_W'(prod_q >> 16) + hdrat_pkg::CURVE_B;
				mul_b = x_q;
			end
			ST_MUL_C: begin
				mul_a = hdrat_pkg::CURVE_C;
				mul_b = x_q;
			end
			ST_MUL_D: begin
				mul_a = hdrat_pkg::MA_W'(prod_q >> 16) + hdrat_pkg::CURVE_D;
				mul_b = x_q;
			end
			ST_MUL_I: begin
				mul_a = hdrat_pkg::MA_W'(y_c);
				mul_b = SPAN;
			end
			default: begin
				mul_a = hdrat_pkg::CURVE_A;
				mul_b = x_c;
			end
		endcase
	end

	assign prod_c = hdrat_pkg::PRD_W'(mul_a) * hdrat_pkg::PRD_W'(mul_b);

	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		lut_q  <= gamma_rom[idx_c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q   <= 6'b110001;
			count_q <= hdrat_pkg::CNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hdrat_pkg::CFG_EXPOSURE: exp_q   <= cfg_data[hdrat_pkg::EXP_W-1:0];
				hdrat_pkg::CFG_COUNT:    count_q <= cfg_data;
				default:                 count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			ch_q    <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						if (command == hdrat_pkg::CMD_RESOLVE) begin
							state_q <= ST_RES_RD;
						end else if (32'(pixel_index) < PIXEL_COUNT) begin
							state_q <= ST_ACC_RD;
						end
					end
				end
				ST_ACC_RD: state_q <= ST_ACC_WR;
				ST_ACC_WR: state_q <= ST_IDLE;
				ST_RES_RD: state_q <= ST_RES_LD;
				ST_RES_LD: begin
					ch_q    <= '0;
					state_q <= ST_CH_LD;
				end
				ST_CH_LD: begin
					step_q  <= '0;
					state_q <= ST_DIV_X;
				end
				ST_DIV_X: begin
					step_q <= step_q + 6'd1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_MUL_A;
					end
				end
				ST_MUL_A: state_q <= ST_MUL_N;
				ST_MUL_N: state_q <= ST_MUL_C;
				ST_MUL_C: state_q <= ST_MUL_D;
				ST_MUL_D: begin
					step_q  <= '0;
					state_q <= ST_DIV_Y;
				end
				ST_DIV_Y: begin
					step_q <= step_q + 6'd1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_MUL_I;
					end
				end
				ST_MUL_I: state_q <= ST_LUT;
				ST_LUT:   state_q <= ST_LUT_WR;
				ST_LUT_WR: begin
					if (ch_q == 2'd2) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_CH_LD;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_LUT_WR) begin
				ch_q <= ch_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q    <= command;
			pix_q    <= pixel_index;
			inside_q <= 32'(pixel_index) < PIXEL_COUNT;
			addr_q   <= AW'(pixel_index);
			smp_q[0] <= red_sample;
			smp_q[1] <= green_sample;
			smp_q[2] <= blue_sample;
		end
		if (state_q == ST_RES_LD) begin
			for (int c = 0; c < 3; c++) begin
				sums_q[c] <= inside_q ? rd_q[c*hdrat_pkg::SUM_W +: hdrat_pkg::SUM_W] : '0;
			end
		end
		unique case (state_q)
			ST_CH_LD: begin
				dq_q  <= hdrat_pkg::DVD_W'(cur_sum);
				dvs_q <= hdrat_pkg::DVS_W'(n_eff);
				rem_q <= '0;
			end
			ST_MUL_D: begin
				dq_q  <= hdrat_pkg::DVD_W'(num_q) << 16;
				dvs_q <= hdrat_pkg::DVS_W'(prod_c) + hdrat_pkg::CURVE_E_Q16;
				rem_q <= '0;
			end
			ST_DIV_X, ST_DIV_Y: begin
				if (!diff[hdrat_pkg::REM_W]) begin
					rem_q <= diff[hdrat_pkg::REM_W-1:0];
					dq_q  <= {dq_q[hdrat_pkg::DVD_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					dq_q  <= {dq_q[hdrat_pkg::DVD_W-2:0], 1'b0};
				end
			end
			default: begin
				dq_q <= dq_q;
			end
		endcase
		if (state_q == ST_MUL_A) begin
			x_q <= x_c;
		end
		if (state_q == ST_MUL_C) begin
			num_q <= hdrat_pkg::DVS_W'(prod_q);
		end
		if (state_q == ST_LUT_WR) begin
			color_q[ch_q] <= (cmd_q == hdrat_pkg::CMD_RESOLVE) ? lut_q : '0;
		end
	end

endmodule
